>>> hdl/bwsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwsc_pkg
// Shared types and constants of the Boltzmann-weighted state correlation block.
// ----------------------------------------------------------------------------
package bwsc_pkg;

	localparam int STATE_BITS     = 4;
	localparam int ACC_W          = 48;
	localparam int WEIGHT_W       = 32;
	localparam int CFG_W          = 32;
	localparam int IDX_W          = 2;

	localparam logic [1:0] REG_MEAN_SCORE    = 2'd0;
	localparam logic [1:0] REG_LEFT_IS_BOND  = 2'd1;
	localparam logic [1:0] REG_RIGHT_IS_BOND = 2'd2;

	localparam logic [15:0] LOG2E_OVER_RT = 16'd36789;
	localparam logic [15:0] POLY_C1 = 16'd45617;
	localparam logic [15:0] POLY_C2 = 16'd14712;
	localparam logic [15:0] POLY_C3 = 16'd5191;
	localparam logic [17:0] THIRD_2 = 18'd32768;
	localparam logic [17:0] THIRD_3 = 18'd21845;

	typedef struct packed {
		logic        [31:0]           sample_score;
		logic        [STATE_BITS-1:0] left_state;
		logic        [STATE_BITS-1:0] right_state;
		logic                         final_sample;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  row_index;
		logic [1:0]  col_index;
		logic [17:0] entry_value;
		logic        last_entry;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic       load;       // capture input item
		logic       calc_y;     // multiply d by constant
		logic [1:0] poly_step;  // Horner step 0..2
		logic       poly_en;
		logic       shift_en;   // form weight
		logic       accum;      // add weight into accumulator
		logic       sum_row;    // compute row sum for row_q
		logic       div_start;  // start divider for (row_q,col_q)
		logic       div_step;
		logic       emit;
		logic       clear;
		logic [1:0] row;
		logic [1:0] col;
		logic       last;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic final_sample;
		logic rows3;
		logic cols3;
		logic div_done;
	} dp_stat_t;

endpackage

>>> hdl/boltzmann_weighted_state_correlation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boltzmann_weighted_state_correlation
// Non-final sample: after accept it runs multiply, Horner steps, shift and
// accumulate, then returns to idle for the next start. Final sample: then a
// row sum per row and, per entry, divider start, serial divide and emit; a
// clear ends it. The 64-step divider sets the rate.
// The receiver cannot stall; result_valid marks each entry for one cycle.
// Reset (arst_n low) asynchronously clears control, config and accumulators.
// ----------------------------------------------------------------------------
module boltzmann_weighted_state_correlation (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  bwsc_pkg::in_item_t         in_item,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [bwsc_pkg::CFG_W-1:0] cfg_data,
	output logic                       result_valid,
	output bwsc_pkg::out_item_t        result
);

	bwsc_pkg::dp_cmd_t  cmd;
	bwsc_pkg::dp_stat_t stat;

	bwsc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	bwsc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_score (in_item.sample_score),
		.left_state   (in_item.left_state),
		.right_state  (in_item.right_state),
		.final_sample (in_item.final_sample),
		.cmd          (cmd),
		.stat         (stat),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

>>> hdl/bwsc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwsc_ctrl
// Sequencer: weight evaluation, accumulate, then row-normalize and emit.
// ----------------------------------------------------------------------------
module bwsc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  bwsc_pkg::dp_stat_t stat,
	output bwsc_pkg::dp_cmd_t  cmd
);

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_MUL   = 10'b0000000010,
		S_POLY  = 10'b0000000100,
		S_SHIFT = 10'b0000001000,
		S_ACC   = 10'b0000010000,
		S_ROW   = 10'b0000100000,
		S_DIVS  = 10'b0001000000,
		S_DIV   = 10'b0010000000,
		S_EMIT  = 10'b0100000000,
		S_CLR   = 10'b1000000000
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] step_q, step_d;
	logic [1:0] row_q, row_d;
	logic [1:0] col_q, col_d;
	logic [1:0] row_max, col_max;

	assign row_max = stat.rows3 ? 2'd2 : 2'd1;
	assign col_max = stat.cols3 ? 2'd2 : 2'd1;
	assign busy    = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		row_d   = row_q;
		col_d   = col_q;
		cmd     = '0;
		cmd.row = row_q;
		cmd.col = col_q;
		cmd.last = (row_q == row_max) && (col_q == col_max);
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_MUL;
				end
			end
			S_MUL: begin
				cmd.calc_y = 1'b1;
				step_d     = 2'd0;
				state_d    = S_POLY;
			end
			S_POLY: begin
				cmd.poly_en   = 1'b1;
				cmd.poly_step = step_q;
				step_d        = step_q + 2'd1;
				if (step_q == 2'd2) state_d = S_SHIFT;
			end
			S_SHIFT: begin
				cmd.shift_en = 1'b1;
				state_d      = S_ACC;
			end
			S_ACC: begin
				cmd.accum = 1'b1;
				row_d     = 2'd0;
				col_d     = 2'd0;
				state_d   = stat.final_sample ? S_ROW : S_IDLE;
			end
			S_ROW: begin
				cmd.sum_row = 1'b1;
				state_d     = S_DIVS;
			end
			S_DIVS: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_done) state_d = S_EMIT;
			end
			S_EMIT: begin
				cmd.emit = 1'b1;
				if (col_q == col_max) begin
					col_d = 2'd0;
					if (row_q == row_max) begin
						state_d = S_CLR;
					end else begin
						row_d   = row_q + 2'd1;
						state_d = S_ROW;
					end
				end else begin
					col_d   = col_q + 2'd1;
					state_d = S_DIVS;
				end
			end
			S_CLR: begin
				cmd.clear = 1'b1;
				state_d   = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= 2'd0;
			row_q   <= 2'd0;
			col_q   <= 2'd0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			row_q   <= row_d;
			col_q   <= col_d;
		end
	end

	a_start_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> state_q == S_IDLE)
		else $error("load outside idle");
	a_emit_to_next: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.last) |=> state_q == S_CLR)
		else $error("no clear after last entry");
	a_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> !busy)
		else $error("busy after clear");

endmodule

>>> hdl/bwsc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwsc_dp
// Datapath: exp weight, accumulators, row sums, serial divider, output reg.
// ----------------------------------------------------------------------------
module bwsc_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [1:0]                      cfg_index,
	input  logic [bwsc_pkg::CFG_W-1:0]      cfg_data,
	input  logic [31:0]                     sample_score,
	input  logic [bwsc_pkg::STATE_BITS-1:0] left_state,
	input  logic [bwsc_pkg::STATE_BITS-1:0] right_state,
	input  logic                            final_sample,
	input  bwsc_pkg::dp_cmd_t               cmd,
	output bwsc_pkg::dp_stat_t              stat,
	output logic                            result_valid,
	output bwsc_pkg::out_item_t             result
);

	localparam int AW = bwsc_pkg::ACC_W;
	localparam int LB = (bwsc_pkg::STATE_BITS < 4) ? bwsc_pkg::STATE_BITS : 4;
	localparam logic [AW-1:0] ACC_MAX = {AW{1'b1}};

	logic signed [31:0] mean_q;
	logic               lb_q, rb_q;
	logic signed [32:0] d_q;
	logic               sat_q;
	logic               fin_q;
	logic [1:0]         l_q, r_q;
	logic               ok_q;
	logic signed [49:0] y_q;
	logic [16:0]        h_q;
	logic [31:0]        w_q;
	logic [AW-1:0]      acc_q [9];
	logic [AW+1:0]      tot_q;
	logic [AW+15:0]     rem_q;
	logic [AW+15:0]     num_q;
	logic [AW+15:0]     quo_q;
	logic [6:0]         cnt_q;
	logic               div_busy_q;
	logic [3:0]         acc_sel;

	function automatic logic [2:0] low_idx(input logic [bwsc_pkg::STATE_BITS-1:0] s);
		logic [2:0] r;
		r = 3'd7;
		for (int i = LB - 1; i >= 0; i--)
			if (s[i]) r = (i == 3) ? 3'd0 : 3'(i);
		return r;
	endfunction

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_q <= '0;
			lb_q   <= 1'b0;
			rb_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bwsc_pkg::REG_MEAN_SCORE:    mean_q <= cfg_data;
				bwsc_pkg::REG_LEFT_IS_BOND:  lb_q   <= cfg_data[0];
				bwsc_pkg::REG_RIGHT_IS_BOND: rb_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign stat.rows3        = lb_q;
	assign stat.cols3        = rb_q;
	assign stat.final_sample = fin_q;
	assign stat.div_done     = div_busy_q && (cnt_q == 7'd0);

	logic [2:0] li, ri;
	assign li = low_idx(left_state);
	assign ri = low_idx(right_state);

	// Weight evaluation
	logic signed [32:0] d_cl;
	logic [32:0]        f_prod;
	logic [15:0]        f_frac;
	logic signed [7:0]  n_exp;
	logic [16:0]        c_next;
	logic [16:0]        m_val;
	logic [52:0]        w_sh;

	assign d_cl   = (d_q < -(33'sd32 <<< 16)) ? -(33'sd32 <<< 16) : d_q;
	assign f_frac = y_q[31:16];
	assign n_exp  = 8'(y_q[49:32]);
	assign f_prod = 33'(h_q) * 33'(f_frac);
	assign m_val  = 17'd65536 + 17'(f_prod >> 16);

	always_comb begin
		unique case (cmd.poly_step)
			2'd0:    c_next = 17'(bwsc_pkg::POLY_C2) + 17'(f_prod >> 16);
			2'd1:    c_next = 17'(bwsc_pkg::POLY_C1) + 17'(f_prod >> 16);
			default: c_next = 17'(bwsc_pkg::POLY_C1);
		endcase
		if (n_exp >= 0) w_sh = 53'(m_val) << n_exp[4:0];
		else            w_sh = 53'(m_val) >> 6'(-n_exp);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			d_q   <= 33'(signed'(mean_q)) - 33'(signed'(sample_score));
			fin_q <= final_sample;
			l_q   <= li[1:0];
			r_q   <= ri[1:0];
			ok_q  <= !li[2] && !ri[2] && (lb_q || li[1:0] != 2'd2)
			         && (rb_q || ri[1:0] != 2'd2);
		end
		if (cmd.calc_y) begin
			sat_q <= d_q >= (33'sd29 <<< 16);
			y_q   <= 50'(d_cl) * 50'(signed'({1'b0, bwsc_pkg::LOG2E_OVER_RT}));
			h_q   <= 17'(bwsc_pkg::POLY_C3);
		end
		if (cmd.poly_en && cmd.poly_step != 2'd2) h_q <= c_next;
		if (cmd.shift_en) begin
			if (sat_q || n_exp > 8'sd20 || w_sh > 53'hFFFFFFFF) w_q <= '1;
			else if (n_exp <= -8'sd40)                           w_q <= '0;
			else                                                 w_q <= w_sh[31:0];
		end
	end

	// Accumulators
	logic [AW:0] acc_add;
	assign acc_sel = 4'(l_q) * 4'd3 + 4'(r_q);
	assign acc_add = {1'b0, acc_q[acc_sel]} + (AW+1)'(w_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) acc_q[i] <= '0;
		end else if (cmd.clear) begin
			for (int i = 0; i < 9; i++) acc_q[i] <= '0;
		end else if (cmd.accum && ok_q) begin
			acc_q[acc_sel] <= acc_add[AW] ? ACC_MAX : acc_add[AW-1:0];
		end
	end

	// Row sum and restoring divider, one quotient bit per cycle
	logic [3:0]     base;
	logic [3:0]     ecell;
	logic [AW+16:0] trial;
	assign base  = 4'(cmd.row) * 4'd3;
	assign ecell = base + 4'(cmd.col);
	assign trial = {rem_q, num_q[AW+15]} - (AW+17)'(tot_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q   <= 1'b0;
			cnt_q        <= '0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= cmd.emit;
			if (cmd.div_start) begin
				div_busy_q <= 1'b1;
				cnt_q      <= 7'(AW + 16);
			end else if (cmd.div_step && cnt_q != 7'd0) begin
				cnt_q <= cnt_q - 7'd1;
			end else if (cmd.emit) begin
				div_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sum_row)
			tot_q <= (AW+2)'(acc_q[base]) + (AW+2)'(acc_q[base + 4'd1])
			         + (rb_q ? (AW+2)'(acc_q[base + 4'd2]) : '0);
		if (cmd.div_start) begin
			rem_q <= '0;
			num_q <= {acc_q[ecell], 16'd0};
			quo_q <= '0;
		end else if (cmd.div_step && cnt_q != 7'd0) begin
			num_q <= num_q << 1;
			if (!trial[AW+16]) begin
				rem_q <= trial[AW+15:0];
				quo_q <= {quo_q[AW+14:0], 1'b1};
			end else begin
				rem_q <= {rem_q[AW+14:0], num_q[AW+15]};
				quo_q <= {quo_q[AW+14:0], 1'b0};
			end
		end
		if (cmd.emit) begin
			result.row_index   <= cmd.row;
			result.col_index   <= cmd.col;
			result.last_entry  <= cmd.last;
			result.entry_value <= (tot_q == '0) ? 18'd0 :
				quo_q[17:0] - (rb_q ? bwsc_pkg::THIRD_3 : bwsc_pkg::THIRD_2);
		end
	end

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> cnt_q == 7'(AW + 16))
		else $error("divider count not loaded");
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> result_valid)
		else $error("emit without strobe");
	a_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> acc_q[0] == '0 && acc_q[4] == '0 && acc_q[8] == '0)
		else $error("accumulators not cleared");

endmodule
